// ===== rtl/spm_pkg.sv =====
package spm_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned MAG_W    = 16;
    localparam int unsigned MULT_W   = 16;
    localparam int unsigned AGE_W    = 16;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned IDX_W    = 2;

    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned S_TUSER_W = 4;
    localparam int unsigned M_TDATA_W = 72;

    localparam logic [MAG_W-1:0] FULL_SCALE = 16'd32767;
    localparam logic [AGE_W-1:0] AGE_MAX    = 16'hFFFF;

    localparam logic [CFG_W-1:0] LEVEL_MULT_RST = 16'd59488;
    localparam logic [CFG_W-1:0] HOLD_MULT_RST  = 16'd61401;
    localparam logic [CFG_W-1:0] HOLD_TICKS_RST = 16'd60;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_TICK   = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef enum logic [IDX_W-1:0] {
        REG_LEVEL_MULT = 2'd0,
        REG_HOLD_MULT  = 2'd1,
        REG_HOLD_TICKS = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [MAG_W-1:0] acc;
        logic [MAG_W-1:0] level;
        logic [MAG_W-1:0] hold;
        logic [AGE_W-1:0] age;
        logic             clip;
    } t_chan;

endpackage

// ===== rtl/stereo_peak_meter_ballistics.sv =====
// Stereo peak meter with level release, peak hold and clip latches.
// One output register: a transaction's result is on o_m_* in the cycle after it is accepted.
// Throughput: one transaction per cycle while not stalled; o_s_tready follows i_m_tready.
// Tick path: one 16x16 Q0.16 multiply per level and per hold, then a select.
// Reset (i_rst_n low, synchronous): all meter state zero, registers to defaults.
module stereo_peak_meter_ballistics (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [spm_pkg::IDX_W-1:0]      i_cfg_index,
    input  logic [spm_pkg::CFG_W-1:0]      i_cfg_data,
    // input stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [15:0] sample_left, [31:16] sample_right
    input  logic [spm_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // [1:0] op, [2] mono_in, [3] clear_channel
    input  logic [spm_pkg::S_TUSER_W-1:0]  i_s_tuser,
    // output stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [15:0] level_left, [31:16] level_right, [47:32] hold_left,
    // [63:48] hold_right, [64] clip_left, [65] clip_right, [71:66] zero
    output logic [spm_pkg::M_TDATA_W-1:0]  o_m_tdata,
    // [0] mono_out
    output logic                           o_m_tuser
);
    import spm_pkg::*;

    logic [CFG_W-1:0] r_level_mult;
    logic [CFG_W-1:0] r_hold_mult;
    logic [CFG_W-1:0] r_hold_ticks;

    t_chan r_left, r_right, n_left, n_right;
    logic  r_mono_pending, n_mono_pending;
    logic  r_mono_latched, n_mono_latched;

    logic                 r_m_tvalid;
    logic [M_TDATA_W-1:0] r_m_tdata;
    logic                 r_m_tuser;

    logic             s_fire;
    t_op              in_op;
    logic             in_mono;
    logic             in_clear_ch;
    logic [MAG_W-1:0] mag_l, mag_r, mag_r_sel;

    function automatic logic [MAG_W-1:0] f_mag(logic [SAMPLE_W-1:0] s);
        logic [MAG_W-1:0] m;
        m = s[SAMPLE_W-1] ? MAG_W'(~s + 1'b1) : MAG_W'(s);
        return m;
    endfunction

    function automatic logic [MAG_W-1:0] f_scale(logic [MAG_W-1:0] x,
                                                 logic [MULT_W-1:0] m);
        logic [MAG_W+MULT_W-1:0] prod;
        prod = {{MULT_W{1'b0}}, x} * {{MAG_W{1'b0}}, m};
        return prod[MAG_W+MULT_W-1:MULT_W];
    endfunction

    function automatic t_chan f_tick(t_chan c, logic [MULT_W-1:0] lvl_m,
                                     logic [MULT_W-1:0] hold_m,
                                     logic [AGE_W-1:0] ticks);
        t_chan            t;
        logic [AGE_W-1:0] age_inc;
        t       = c;
        t.acc   = '0;
        t.level = (c.acc > c.level) ? c.acc : f_scale(c.level, lvl_m);
        age_inc = (c.age != AGE_MAX) ? c.age + 1'b1 : c.age;
        if (c.acc >= c.hold) begin
            t.hold = c.acc;
            t.age  = '0;
        end else begin
            t.age  = age_inc;
            t.hold = (age_inc > ticks) ? f_scale(c.hold, hold_m) : c.hold;
        end
        if (c.acc >= FULL_SCALE) begin
            t.clip = 1'b1;
        end
        return t;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_m_tvalid || i_m_tready;
    assign s_fire      = i_s_tvalid && o_s_tready;

    assign in_op       = t_op'(i_s_tuser[1:0]);
    assign in_mono     = i_s_tuser[2];
    assign in_clear_ch = i_s_tuser[3];
    assign mag_l       = f_mag(i_s_tdata[15:0]);
    assign mag_r       = f_mag(i_s_tdata[31:16]);
    assign mag_r_sel   = in_mono ? mag_l : mag_r;

    always_comb begin
        n_left         = r_left;
        n_right        = r_right;
        n_mono_pending = r_mono_pending;
        n_mono_latched = r_mono_latched;
        unique case (in_op)
            OP_SAMPLE: begin
                n_mono_pending = in_mono;
                if (mag_l > r_left.acc) begin
                    n_left.acc = mag_l;
                end
                if (mag_r_sel > r_right.acc) begin
                    n_right.acc = mag_r_sel;
                end
            end
            OP_TICK: begin
                n_mono_latched = r_mono_pending;
                n_left  = f_tick(r_left, r_level_mult, r_hold_mult, r_hold_ticks);
                n_right = f_tick(r_right, r_level_mult, r_hold_mult, r_hold_ticks);
            end
            OP_CLEAR: begin
                if (in_clear_ch) begin
                    n_right.clip = 1'b0;
                end else begin
                    n_left.clip = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_mult <= LEVEL_MULT_RST;
            r_hold_mult  <= HOLD_MULT_RST;
            r_hold_ticks <= HOLD_TICKS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_LEVEL_MULT: r_level_mult <= i_cfg_data;
                REG_HOLD_MULT:  r_hold_mult  <= i_cfg_data;
                REG_HOLD_TICKS: r_hold_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left         <= '0;
            r_right        <= '0;
            r_mono_pending <= 1'b0;
            r_mono_latched <= 1'b0;
        end else if (s_fire) begin
            r_left         <= n_left;
            r_right        <= n_right;
            r_mono_pending <= n_mono_pending;
            r_mono_latched <= n_mono_latched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (o_s_tready) begin
            r_m_tvalid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_m_tdata <= {6'b0, n_right.clip, n_left.clip, n_right.hold, n_left.hold,
                          n_right.level, n_left.level};
            r_m_tuser <= n_mono_latched;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

    a_clip_clear_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_left.clip) |-> $past(s_fire && in_op == OP_CLEAR && !in_clear_ch))
        else $error("left clip latch dropped without a clear transaction");

    a_tick_clears_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && in_op == OP_TICK) |=> (r_left.acc == '0 && r_right.acc == '0))
        else $error("peak accumulators not cleared by tick");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left.level <= 16'h8000 && r_right.level <= 16'h8000 &&
         r_left.hold <= 16'h8000 && r_right.hold <= 16'h8000))
        else $error("level or hold above full-scale magnitude");

    a_valid_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(s_fire))
        else $error("output valid without an accepted transaction");

endmodule
